// ----- hw/rtl/asad_pkg.sv -----
// ----------------------------------------------------------------------------
// asad_pkg
// Shared types, constants and shift-add reciprocal programs for the
// approximate shift-add divider.
// ----------------------------------------------------------------------------
package asad_pkg;

    // Default datapath width and fixed port width
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int IO_WIDTH        = 32;

    // Small divisors are 0..16
    localparam int SDIV_W          = 5;

    // Reciprocal program: six steps, two per pipeline stage
    localparam int NUM_STEPS       = 6;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CHAIN_STAGES    = NUM_STEPS / STEPS_PER_STAGE;

    // Lanes: primary divisor, divisor plus one, and divisor nine (17 case)
    localparam int NUM_LANES       = 3;
    localparam int LANE_LO         = 0;
    localparam int LANE_HI         = 1;
    localparam int LANE_AUX        = 2;

    // Step operations
    //   OP_NONE : q = q >> r
    //   OP_SHADD: q = (q + (q >> k)) >> r
    //   OP_PLUS : q = (q + a) >> r
    //   OP_CLEAR: q = 0
    typedef enum logic [1:0] {
        OP_NONE,
        OP_SHADD,
        OP_PLUS,
        OP_CLEAR
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [3:0] k;
        logic [2:0] r;
    } chain_step_t;

    typedef chain_step_t [NUM_STEPS-1:0] chain_prog_t;

    // Control that travels with a request past normalization
    typedef struct packed {
        logic is_small;   // divisor 0..16, quotient comes from one chain
        logic special;    // divisor plus one is 17: use mean of 8 and 9
    } norm_ctl_t;

    function automatic chain_step_t mk_step(input op_kind_t kind,
                                            input logic [3:0] k,
                                            input logic [2:0] r);
        chain_step_t s;
        s.kind = kind;
        s.k    = k;
        s.r    = r;
        return s;
    endfunction

    // Shift-add program per small divisor; unused steps are plain passes
    function automatic chain_prog_t chain_prog(input logic [SDIV_W-1:0] d);
        chain_prog_t p;
        for (int i = 0; i < NUM_STEPS; i++) begin
            p[i] = mk_step(OP_NONE, 4'd0, 3'd0);
        end
        case (d)
            5'd0:  p[0] = mk_step(OP_CLEAR, 4'd0, 3'd0);
            5'd1:  p[0] = mk_step(OP_NONE, 4'd0, 3'd0);
            5'd2:  p[0] = mk_step(OP_NONE, 4'd0, 3'd1);
            5'd4:  p[0] = mk_step(OP_NONE, 4'd0, 3'd2);
            5'd8:  p[0] = mk_step(OP_NONE, 4'd0, 3'd3);
            5'd16: p[0] = mk_step(OP_NONE, 4'd0, 3'd4);
            5'd3:
            begin
                p[0] = mk_step(OP_SHADD, 4'd2, 3'd2);
                p[1] = mk_step(OP_PLUS, 4'd0, 3'd1);
                p[2] = mk_step(OP_SHADD, 4'd6, 3'd0);
                p[3] = mk_step(OP_SHADD, 4'd12, 3'd1);
            end
            5'd5, 5'd10:
            begin
                p[0] = mk_step(OP_SHADD, 4'd1, 3'd1);
                p[1] = mk_step(OP_SHADD, 4'd4, 3'd0);
                p[2] = mk_step(OP_SHADD, 4'd8, (d == 5'd5) ? 3'd2 : 3'd3);
            end
            5'd6, 5'd12:
            begin
                p[0] = mk_step(OP_SHADD, 4'd2, 3'd1);
                p[1] = mk_step(OP_SHADD, 4'd4, 3'd0);
                p[2] = mk_step(OP_SHADD, 4'd8, (d == 5'd6) ? 3'd2 : 3'd3);
            end
            5'd7, 5'd14:
            begin
                p[0] = mk_step(OP_SHADD, 4'd3, 3'd1);
                p[1] = mk_step(OP_SHADD, 4'd6, 3'd0);
                p[2] = mk_step(OP_SHADD, 4'd12, (d == 5'd7) ? 3'd2 : 3'd3);
            end
            5'd9:
            begin
                p[0] = mk_step(OP_SHADD, 4'd1, 3'd1);
                p[1] = mk_step(OP_PLUS, 4'd0, 3'd1);
                p[2] = mk_step(OP_SHADD, 4'd6, 3'd0);
                p[3] = mk_step(OP_SHADD, 4'd12, 3'd3);
            end
            5'd11:
            begin
                p[0] = mk_step(OP_SHADD, 4'd2, 3'd1);
                p[1] = mk_step(OP_PLUS, 4'd0, 3'd1);
                p[2] = mk_step(OP_PLUS, 4'd0, 3'd2);
                p[3] = mk_step(OP_PLUS, 4'd0, 3'd1);
                p[4] = mk_step(OP_SHADD, 4'd10, 3'd3);
            end
            5'd13:
            begin
                p[0] = mk_step(OP_SHADD, 4'd1, 3'd2);
                p[1] = mk_step(OP_PLUS, 4'd0, 3'd1);
                p[2] = mk_step(OP_PLUS, 4'd0, 3'd1);
                p[3] = mk_step(OP_PLUS, 4'd0, 3'd3);
                p[4] = mk_step(OP_PLUS, 4'd0, 3'd1);
                p[5] = mk_step(OP_SHADD, 4'd12, 3'd3);
            end
            5'd15:
            begin
                p[0] = mk_step(OP_SHADD, 4'd4, 3'd1);
                p[1] = mk_step(OP_SHADD, 4'd8, 3'd3);
            end
            default: p[0] = mk_step(OP_CLEAR, 4'd0, 3'd0);
        endcase
        return p;
    endfunction

endpackage

// ----- hw/rtl/asad_lzd.sv -----
// ----------------------------------------------------------------------------
// asad_lzd
// Two-stage leading-one search on the divisor: per-byte encode, then pick
// the highest nonzero byte and form the base right-shift amount.
// ----------------------------------------------------------------------------
module asad_lzd
    import asad_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int NG        = (DATA_WIDTH + 7) / 8,
    localparam int GW        = (NG > 1) ? $clog2(NG) : 1,
    localparam int MW        = GW + 3
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [DATA_WIDTH-1:0] a_in,
    input  logic [DATA_WIDTH-1:0] d_in,
    output logic [DATA_WIDTH-1:0] a_out,
    output logic [DATA_WIDTH-1:0] d_out,
    output logic                  is_small_out,
    output logic [MW-1:0]         sh_out
);

    localparam int PADW = NG * 8;

    logic [PADW-1:0]       d_pad;
    logic [NG-1:0]         grp_nz_next;
    logic [2:0]            grp_pos_next [NG];

    logic [NG-1:0]         grp_nz_reg;
    logic [2:0]            grp_pos_reg [NG];
    logic [DATA_WIDTH-1:0] a1_reg;
    logic [DATA_WIDTH-1:0] d1_reg;
    logic                  small1_reg;

    logic [MW-1:0]         msb;
    logic [MW-1:0]         sh_next;

    logic [DATA_WIDTH-1:0] a2_reg;
    logic [DATA_WIDTH-1:0] d2_reg;
    logic                  small2_reg;
    logic [MW-1:0]         sh_reg;

    // Stage 1: leading-one position inside each byte
    always_comb
    begin
        d_pad = PADW'(d_in);
        for (int g = 0; g < NG; g++) begin
            grp_nz_next[g]  = |d_pad[g*8 +: 8];
            grp_pos_next[g] = 3'd0;
            for (int j = 0; j < 8; j++) begin
                if (d_pad[g*8 + j]) begin
                    grp_pos_next[g] = 3'(j);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            grp_nz_reg <= grp_nz_next;
            grp_pos_reg <= grp_pos_next;
            a1_reg <= a_in;
            d1_reg <= d_in;
            small1_reg <= (d_in <= DATA_WIDTH'(16));
        end
    end

    // Stage 2: highest nonzero byte gives the divisor msb
    always_comb
    begin
        msb = '0;
        for (int g = 0; g < NG; g++) begin
            if (grp_nz_reg[g]) begin
                msb = {GW'(g), grp_pos_reg[g]};
            end
        end
        // shift that leaves the divisor in 16..31
        sh_next = small1_reg ? '0 : (msb - MW'(4));
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            a2_reg <= a1_reg;
            d2_reg <= d1_reg;
            small2_reg <= small1_reg;
            sh_reg <= sh_next;
        end
    end

    assign a_out        = a2_reg;
    assign d_out        = d2_reg;
    assign is_small_out = small2_reg;
    assign sh_out       = sh_reg;

endmodule

// ----- hw/rtl/asad_norm.sv -----
// ----------------------------------------------------------------------------
// asad_norm
// Shifts dividend and divisor right together so a divisor above 16 is 8..16
// (small divisors pass unshifted) and sets up the operands of the three reciprocal lanes.
// ----------------------------------------------------------------------------
module asad_norm
    import asad_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int MW         = 4
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [DATA_WIDTH-1:0] a_in,
    input  logic [DATA_WIDTH-1:0] d_in,
    input  logic                  is_small_in,
    input  logic [MW-1:0]         sh_in,
    output logic [DATA_WIDTH-1:0] a_lo_out,
    output logic [SDIV_W-1:0]     d_lo_out,
    output logic [DATA_WIDTH-1:0] a_hi_out,
    output logic [SDIV_W-1:0]     d_hi_out,
    output logic [DATA_WIDTH-1:0] a_aux_out,
    output norm_ctl_t             ctl_out
);

    logic [DATA_WIDTH-1:0] a_t;
    logic [DATA_WIDTH-1:0] d_t;
    logic [SDIV_W-1:0]     t5;
    logic [SDIV_W-1:0]     ds;
    logic [DATA_WIDTH-1:0] a_s;

    logic [DATA_WIDTH-1:0] a_lo_next;
    logic [SDIV_W-1:0]     d_lo_next;
    logic [DATA_WIDTH-1:0] a_hi_next;
    logic [SDIV_W-1:0]     d_hi_next;
    logic [DATA_WIDTH-1:0] a_aux_next;
    norm_ctl_t             ctl_next;

    logic [DATA_WIDTH-1:0] a_lo_reg;
    logic [SDIV_W-1:0]     d_lo_reg;
    logic [DATA_WIDTH-1:0] a_hi_reg;
    logic [SDIV_W-1:0]     d_hi_reg;
    logic [DATA_WIDTH-1:0] a_aux_reg;
    norm_ctl_t             ctl_reg;

    // Barrel shift, then one more bit unless the divisor landed on 16 or is small
    always_comb
    begin
        a_t = a_in >> sh_in;
        d_t = d_in >> sh_in;
        t5  = d_t[SDIV_W-1:0];
        if (is_small_in) begin
            ds  = d_in[SDIV_W-1:0];
            a_s = a_in;
        end else if (t5 == 5'd16) begin
            ds  = t5;
            a_s = a_t;
        end else begin
            ds  = t5 >> 1;
            a_s = a_t >> 1;
        end

        ctl_next.is_small = is_small_in;
        ctl_next.special  = !is_small_in && (ds == 5'd16);
        a_lo_next  = a_s;
        d_lo_next  = ds;
        a_aux_next = a_s >> 1;
        if (is_small_in) begin
            a_hi_next = a_s;
            d_hi_next = ds;
        end else if (ctl_next.special) begin
            a_hi_next = a_s >> 1;
            d_hi_next = 5'd8;
        end else begin
            a_hi_next = a_s;
            d_hi_next = ds + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            a_lo_reg <= a_lo_next;
            d_lo_reg <= d_lo_next;
            a_hi_reg <= a_hi_next;
            d_hi_reg <= d_hi_next;
            a_aux_reg <= a_aux_next;
            ctl_reg <= ctl_next;
        end
    end

    assign a_lo_out  = a_lo_reg;
    assign d_lo_out  = d_lo_reg;
    assign a_hi_out  = a_hi_reg;
    assign d_hi_out  = d_hi_reg;
    assign a_aux_out = a_aux_reg;
    assign ctl_out   = ctl_reg;

endmodule

// ----- hw/rtl/asad_chain.sv -----
// ----------------------------------------------------------------------------
// asad_chain
// One pipeline stage of a shift-add reciprocal lane: runs two program steps
// of the small divisor and registers the partial quotient.
// ----------------------------------------------------------------------------
module asad_chain
    import asad_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FIRST_STEP = 0
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [DATA_WIDTH-1:0] a_in,
    input  logic [SDIV_W-1:0]     d_in,
    input  logic [DATA_WIDTH-1:0] q_in,
    output logic [DATA_WIDTH-1:0] a_out,
    output logic [SDIV_W-1:0]     d_out,
    output logic [DATA_WIDTH-1:0] q_out
);

    chain_prog_t           prog;
    chain_step_t           st;
    logic [DATA_WIDTH-1:0] sum;
    logic [DATA_WIDTH-1:0] q_next;

    logic [DATA_WIDTH-1:0] a_reg;
    logic [SDIV_W-1:0]     d_reg;
    logic [DATA_WIDTH-1:0] q_reg;

    // Two steps; sums wrap at the datapath width before the post shift
    always_comb
    begin
        prog   = chain_prog(d_in);
        q_next = q_in;
        st     = prog[FIRST_STEP];
        sum    = '0;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            st = prog[FIRST_STEP + i];
            case (st.kind)
                OP_NONE:
                begin
                    q_next = q_next >> st.r;
                end
                OP_SHADD:
                begin
                    sum    = q_next + (q_next >> st.k);
                    q_next = sum >> st.r;
                end
                OP_PLUS:
                begin
                    sum    = q_next + a_in;
                    q_next = sum >> st.r;
                end
                OP_CLEAR:
                begin
                    q_next = '0;
                end
                default:
                begin
                    q_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            a_reg <= a_in;
            d_reg <= d_in;
            q_reg <= q_next;
        end
    end

    assign a_out = a_reg;
    assign d_out = d_reg;
    assign q_out = q_reg;

endmodule

// ----- hw/rtl/approx_shift_add_divider.sv -----
// ----------------------------------------------------------------------------
// approx_shift_add_divider
// Approximate unsigned divider built from shift-add reciprocal chains.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries dividend and divisor on in_valid/in_ready; the result
//   leaves as quotient on out_valid/out_ready. The quotient is approximate;
//   a zero divisor gives zero. From acceptance to out_valid a request
//   passes two stages of leading-one search, one normalizing barrel shift,
//   three reciprocal stages (two shift-add steps each, three lanes in
//   parallel) and the averaging output register.
//   Throughput is one request per cycle; the pipeline takes a new request
//   every cycle while the output register is empty or being drained.
//   When the receiver holds out_ready low with a result waiting, the whole
//   pipeline freezes in place and in_ready drops; nothing is lost or
//   repeated. Reset clears the valid bits only; the block holds no state
//   beyond the requests in flight.
// ----------------------------------------------------------------------------
module approx_shift_add_divider
    import asad_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [IO_WIDTH-1:0] dividend,
    input  logic [IO_WIDTH-1:0] divisor,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IO_WIDTH-1:0] quotient
);

    localparam int NG     = (DATA_WIDTH + 7) / 8;
    localparam int GW     = (NG > 1) ? $clog2(NG) : 1;
    localparam int MW     = GW + 3;
    localparam int NSTAGE = 2 + 1 + CHAIN_STAGES + 1;

    logic                  en;
    logic [NSTAGE-1:0]     vld_reg;

    logic [DATA_WIDTH-1:0] lz_a;
    logic [DATA_WIDTH-1:0] lz_d;
    logic                  lz_small;
    logic [MW-1:0]         lz_sh;

    norm_ctl_t             nm_ctl;
    norm_ctl_t             ctl_reg [CHAIN_STAGES];

    logic [DATA_WIDTH-1:0] ch_a [NUM_LANES][CHAIN_STAGES+1];
    logic [SDIV_W-1:0]     ch_d [NUM_LANES][CHAIN_STAGES+1];
    logic [DATA_WIDTH-1:0] ch_q [NUM_LANES][CHAIN_STAGES+1];

    logic [DATA_WIDTH-1:0] hi_sum;
    logic [DATA_WIDTH-1:0] hi_val;
    logic [DATA_WIDTH-1:0] mean_sum;
    logic [DATA_WIDTH-1:0] res_next;
    logic [IO_WIDTH-1:0]   quotient_reg;

    // Global advance: move whenever the output slot is free or draining
    assign en       = !vld_reg[NSTAGE-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
        end
    end

    // Leading-one search on the divisor
    asad_lzd #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_lzd (
        .clk          (clk),
        .en           (en),
        .a_in         (DATA_WIDTH'(dividend)),
        .d_in         (DATA_WIDTH'(divisor)),
        .a_out        (lz_a),
        .d_out        (lz_d),
        .is_small_out (lz_small),
        .sh_out       (lz_sh)
    );

    // Normalize a divisor above 16 to 8..16 and set up the lanes
    asad_norm #(
        .DATA_WIDTH (DATA_WIDTH),
        .MW         (MW)
    ) u_norm (
        .clk         (clk),
        .en          (en),
        .a_in        (lz_a),
        .d_in        (lz_d),
        .is_small_in (lz_small),
        .sh_in       (lz_sh),
        .a_lo_out    (ch_a[LANE_LO][0]),
        .d_lo_out    (ch_d[LANE_LO][0]),
        .a_hi_out    (ch_a[LANE_HI][0]),
        .d_hi_out    (ch_d[LANE_HI][0]),
        .a_aux_out   (ch_a[LANE_AUX][0]),
        .ctl_out     (nm_ctl)
    );

    // Auxiliary lane always divides by nine
    assign ch_d[LANE_AUX][0] = SDIV_W'(9);

    // Reciprocal lanes, two steps per stage
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        assign ch_q[l][0] = ch_a[l][0];
        for (genvar s = 0; s < CHAIN_STAGES; s++) begin : g_stage
            asad_chain #(
                .DATA_WIDTH (DATA_WIDTH),
                .FIRST_STEP (s * STEPS_PER_STAGE)
            ) u_chain (
                .clk   (clk),
                .en    (en),
                .a_in  (ch_a[l][s]),
                .d_in  (ch_d[l][s]),
                .q_in  (ch_q[l][s]),
                .a_out (ch_a[l][s+1]),
                .d_out (ch_d[l][s+1]),
                .q_out (ch_q[l][s+1])
            );
        end
    end

    // Lane control follows the chain stages
    always_ff @(posedge clk)
    begin
        if (en) begin
            ctl_reg[0] <= nm_ctl;
            for (int s = 1; s < CHAIN_STAGES; s++) begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    // Average the lanes (a small divisor takes the primary lane alone); sums wrap at the datapath width
    always_comb
    begin
        hi_sum   = ch_q[LANE_HI][CHAIN_STAGES] + ch_q[LANE_AUX][CHAIN_STAGES];
        hi_val   = ctl_reg[CHAIN_STAGES-1].special ? (hi_sum >> 1)
                                                   : ch_q[LANE_HI][CHAIN_STAGES];
        mean_sum = ch_q[LANE_LO][CHAIN_STAGES] + hi_val;
        res_next = ctl_reg[CHAIN_STAGES-1].is_small ? ch_q[LANE_LO][CHAIN_STAGES]
                                                    : (mean_sum >> 1);
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en) begin
            quotient_reg <= IO_WIDTH'(res_next);
        end
    end

    assign out_valid = vld_reg[NSTAGE-1];
    assign quotient  = quotient_reg;

endmodule
